FILE: sv/rgbk_pkg.sv
package rgbk_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int PIX_W = 8;
	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int MODE_W = 2;
	localparam int IMGW_W = 11;
	localparam int IMGH_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int MIN_DIM = 3;
	localparam int HEIGHT_MAX = 4096;
	localparam int BLUR_MUL = 7209;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLUR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_RESET = MODE_EDGE;
	localparam logic [IMGW_W-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [IMGH_W-1:0] HEIGHT_RESET = 13'd1024;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		pixel_t [8:0] win;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic last;
	} item_t;

	typedef struct packed {
		logic empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

FILE: sv/rgbk_ram.sv
module rgbk_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/rgbk_front.sv
module rgbk_front #(
	parameter int MAX_WIDTH = rgbk_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [rgbk_pkg::PIX_W-1:0]    pixel_red,
	input  logic [rgbk_pkg::PIX_W-1:0]    pixel_green,
	input  logic [rgbk_pkg::PIX_W-1:0]    pixel_blue,
	input  logic [rgbk_pkg::IMGW_W-1:0]   image_width,
	input  logic [rgbk_pkg::IMGH_W-1:0]   image_height,
	input  rgbk_pkg::qstat_t              q_stat,
	output logic                          q_push,
	output rgbk_pkg::item_t               q_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int HW = rgbk_pkg::IMGH_W;
	localparam int RW = rgbk_pkg::ROW_W;
	localparam int LW = 2 * $bits(rgbk_pkg::pixel_t);
	localparam int OW = rgbk_pkg::QCNT_W + 1;

	logic [EW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW:0]   col_p1;
	logic [RW:0]   row_p1;
	logic          accept;
	logic          emit;
	logic          last;

	logic                        v_s1;
	logic                        emit_s1;
	rgbk_pkg::pixel_t            px_s1;
	logic [CW-1:0]               col_s1;
	logic [rgbk_pkg::COL_W-1:0]  column_s1;
	logic [RW-1:0]               row_s1;
	logic                        last_s1;

	rgbk_pkg::pixel_t win_q [6];
	rgbk_pkg::pixel_t top;
	rgbk_pkg::pixel_t mid;
	logic [LW-1:0]    rd_data;
	logic [OW-1:0]    occupancy;

	always_comb begin
		if (32'(image_width) < rgbk_pkg::MIN_DIM) begin
			eff_w = EW'(rgbk_pkg::MIN_DIM);
		end else if (32'(image_width) > MAX_WIDTH) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(image_width);
		end
		if (32'(image_height) < rgbk_pkg::MIN_DIM) begin
			eff_h = HW'(rgbk_pkg::MIN_DIM);
		end else if (32'(image_height) > rgbk_pkg::HEIGHT_MAX) begin
			eff_h = HW'(rgbk_pkg::HEIGHT_MAX);
		end else begin
			eff_h = image_height;
		end
	end

	assign accept = push && !full;
	assign col_p1 = (CW+1)'(col_q) + (CW+1)'(1);
	assign row_p1 = (RW+1)'(row_q) + (RW+1)'(1);
	assign emit = (col_q >= CW'(2)) && (row_q >= RW'(2)) &&
		(EW'(col_q) < eff_w) && (HW'(row_q) < eff_h);
	assign last = (EW'(col_q) == eff_w - EW'(1)) && (HW'(row_q) == eff_h - HW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_p1 >= (CW+1)'(eff_w)) begin
				col_q <= '0;
				row_q <= (HW'(row_p1) >= eff_h) ? '0 : RW'(row_p1);
			end else begin
				col_q <= CW'(col_p1);
				row_q <= (HW'(row_q) >= eff_h) ? '0 : row_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			emit_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= '{blue: pixel_blue, green: pixel_green, red: pixel_red};
			col_s1 <= col_q;
			column_s1 <= rgbk_pkg::COL_W'(col_q - CW'(1));
			row_s1 <= row_q - RW'(1);
			last_s1 <= last;
		end
	end

	rgbk_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (v_s1),
		.wr_addr(col_s1),
		.wr_data({mid, px_s1}),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(rd_data)
	);

	assign top = rd_data[LW-1 -: $bits(rgbk_pkg::pixel_t)];
	assign mid = rd_data[$bits(rgbk_pkg::pixel_t)-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			q_item.win[i] = win_q[i];
		end
		q_item.win[6] = top;
		q_item.win[7] = mid;
		q_item.win[8] = px_s1;
		q_item.column = column_s1;
		q_item.row = row_s1;
		q_item.last = last_s1;
	end

	assign q_push = v_s1 && emit_s1;

	// An accepted word may still need a slot in the cycle after it is accepted.
	assign occupancy = OW'(q_stat.count) + OW'(q_push);
	assign full = occupancy >= OW'(rgbk_pkg::QUEUE_DEPTH);

endmodule

FILE: sv/rgbk_queue.sv
module rgbk_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  rgbk_pkg::item_t   wr_item,
	input  logic              rd_en,
	output rgbk_pkg::item_t   rd_item,
	output rgbk_pkg::qstat_t  q_stat
);

	localparam int PW = rgbk_pkg::QPTR_W;
	localparam int NW = rgbk_pkg::QCNT_W;

	rgbk_pkg::item_t mem_q [rgbk_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign do_wr = wr_en && (count_q != NW'(rgbk_pkg::QUEUE_DEPTH));
	assign do_rd = rd_en && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(rgbk_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(rgbk_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	assign rd_item = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.count = count_q;

endmodule

FILE: sv/rgbk_back.sv
module rgbk_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rgbk_pkg::MODE_W-1:0]   filter_mode,
	input  rgbk_pkg::qstat_t              q_stat,
	input  rgbk_pkg::item_t               q_item,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [rgbk_pkg::PIX_W-1:0]    out_red,
	output logic [rgbk_pkg::PIX_W-1:0]    out_green,
	output logic [rgbk_pkg::PIX_W-1:0]    out_blue,
	output logic [rgbk_pkg::COL_W-1:0]    out_column,
	output logic [rgbk_pkg::ROW_W-1:0]    out_row,
	output logic                          frame_last
);

	function automatic logic [7:0] px_chan(rgbk_pkg::pixel_t p, int c);
		logic [7:0] v;
		case (c)
			0: v = p.red;
			1: v = p.green;
			default: v = p.blue;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] kernel_apply(logic [1:0] mode, logic [7:0] centre,
		logic [9:0] cross_sum, logic [9:0] corner, logic [11:0] total);
		logic [12:0] acc;
		logic [24:0] prod;
		logic [7:0]  res;
		acc = '0;
		prod = 25'(total) * 25'(rgbk_pkg::BLUR_MUL);
		case (mode)
			rgbk_pkg::MODE_EDGE: acc = {2'b0, centre, 3'b0} - {3'b0, cross_sum} - {3'b0, corner};
			rgbk_pkg::MODE_SHARPEN: acc = {3'b0, centre, 2'b0} + {5'b0, centre} - {3'b0, cross_sum};
			default: acc = '0;
		endcase
		if (acc[12]) begin
			res = '0;
		end else if (acc[11:0] >= 12'd255) begin
			res = 8'd255;
		end else begin
			res = acc[7:0];
		end
		if (mode == rgbk_pkg::MODE_BLUR) begin
			res = prod[23:16];
		end
		return res;
	endfunction

	logic en;

	logic                        v_s1;
	logic [7:0]                  centre_s1 [3];
	logic [9:0]                  cross_s1 [3];
	logic [9:0]                  corner_s1 [3];
	logic [11:0]                 total_s1 [3];
	logic [rgbk_pkg::COL_W-1:0]  column_s1;
	logic [rgbk_pkg::ROW_W-1:0]  row_s1;
	logic                        last_s1;

	logic                        v_s2;
	logic [7:0]                  chan_s2 [3];
	logic [rgbk_pkg::COL_W-1:0]  column_s2;
	logic [rgbk_pkg::ROW_W-1:0]  row_s2;
	logic                        last_s2;

	logic [9:0]  cross_c [3];
	logic [9:0]  corner_c [3];

	assign en = !v_s2 || pop;
	assign q_pop = en && !q_stat.empty;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cross_c[c] = 10'(px_chan(q_item.win[1], c)) + 10'(px_chan(q_item.win[3], c)) +
				10'(px_chan(q_item.win[5], c)) + 10'(px_chan(q_item.win[7], c));
			corner_c[c] = 10'(px_chan(q_item.win[0], c)) + 10'(px_chan(q_item.win[2], c)) +
				10'(px_chan(q_item.win[6], c)) + 10'(px_chan(q_item.win[8], c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_stat.empty;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				centre_s1[c] <= px_chan(q_item.win[4], c);
				cross_s1[c] <= cross_c[c];
				corner_s1[c] <= corner_c[c];
				total_s1[c] <= 12'(px_chan(q_item.win[4], c)) + 12'(cross_c[c]) +
					12'(corner_c[c]);
				chan_s2[c] <= kernel_apply(filter_mode, centre_s1[c], cross_s1[c],
					corner_s1[c], total_s1[c]);
			end
			column_s1 <= q_item.column;
			row_s1 <= q_item.row;
			last_s1 <= q_item.last;
			column_s2 <= column_s1;
			row_s2 <= row_s1;
			last_s2 <= last_s1;
		end
	end

	assign empty = !v_s2;
	assign out_red = chan_s2[0];
	assign out_green = chan_s2[1];
	assign out_blue = chan_s2[2];
	assign out_column = column_s2;
	assign out_row = row_s2;
	assign frame_last = last_s2;

endmodule

FILE: sv/rgb_3x3_kernel_filter_core.sv
// A completed 3x3 window passes front s1, the window queue, then back s1 and s2 to the output.
// Throughput: one pixel per cycle unless full, set by the line RAM's single read and write port.
// A result that is not popped holds the output; the front keeps accepting until the
// window queue between front and back has no room left.
// Reset (arst_n low) clears counters, window, queue state, valid flags, config; not line RAM.
module rgb_3x3_kernel_filter_core #(
	parameter int MAX_WIDTH = rgbk_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [rgbk_pkg::PIX_W-1:0]        pixel_red,
	input  logic [rgbk_pkg::PIX_W-1:0]        pixel_green,
	input  logic [rgbk_pkg::PIX_W-1:0]        pixel_blue,
	output logic                              empty,
	input  logic                              pop,
	output logic [rgbk_pkg::PIX_W-1:0]        out_red,
	output logic [rgbk_pkg::PIX_W-1:0]        out_green,
	output logic [rgbk_pkg::PIX_W-1:0]        out_blue,
	output logic [rgbk_pkg::COL_W-1:0]        out_column,
	output logic [rgbk_pkg::ROW_W-1:0]        out_row,
	output logic                              frame_last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rgbk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgbk_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [rgbk_pkg::MODE_W-1:0] mode_q;
	logic [rgbk_pkg::IMGW_W-1:0] width_q;
	logic [rgbk_pkg::IMGH_W-1:0] height_q;

	logic             q_push;
	logic             q_pop;
	rgbk_pkg::item_t  wr_item;
	rgbk_pkg::item_t  rd_item;
	rgbk_pkg::qstat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rgbk_pkg::MODE_RESET;
			width_q <= rgbk_pkg::WIDTH_RESET;
			height_q <= rgbk_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rgbk_pkg::REG_FILTER_MODE: mode_q <= cfg_data[rgbk_pkg::MODE_W-1:0];
				rgbk_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data[rgbk_pkg::IMGW_W-1:0];
				rgbk_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[rgbk_pkg::IMGH_W-1:0];
				default: ;
			endcase
		end
	end

	rgbk_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.image_width (width_q),
		.image_height(height_q),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_item      (wr_item)
	);

	rgbk_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_item(wr_item),
		.rd_en  (q_pop),
		.rd_item(rd_item),
		.q_stat (q_stat)
	);

	rgbk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.filter_mode(mode_q),
		.q_stat     (q_stat),
		.q_item     (rd_item),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_column (out_column),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

endmodule

FILE: sv/rgbk_checker.sv
module rgbk_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              push,
	input logic                              full,
	input logic                              empty,
	input logic                              pop,
	input logic [rgbk_pkg::PIX_W-1:0]        out_red,
	input logic [rgbk_pkg::PIX_W-1:0]        out_green,
	input logic [rgbk_pkg::PIX_W-1:0]        out_blue,
	input logic [rgbk_pkg::COL_W-1:0]        out_column,
	input logic [rgbk_pkg::ROW_W-1:0]        out_row,
	input logic                              frame_last
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("Queue sides not idle during reset.");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_red) && $stable(out_green) &&
		$stable(out_blue) && $stable(out_column) && $stable(out_row) &&
		$stable(frame_last)))
		else $error("Stalled result word changed.");

	a_interior_row: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_row != '0))
		else $error("Result word names a border row.");

endmodule

bind rgb_3x3_kernel_filter_core rgbk_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.out_column(out_column),
	.out_row   (out_row),
	.frame_last(frame_last)
);

FILE: verif/rgb_3x3_kernel_filter_core_tb.sv
`timescale 1ns / 1ps

module rgb_3x3_kernel_filter_core_tb;
	import rgbk_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0] DIRECTED_MODES [4] = '{MODE_EDGE, MODE_BLUR, MODE_SHARPEN,
		MODE_UNUSED};
	localparam int BLUR_SCALE = 7209;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 1360;
	localparam int WIDE_WIDTH = 256;
	localparam int WIDE_PIXELS = 2 * WIDE_WIDTH + 40;
	localparam int PRESSURE_PHASE = 3;

	typedef struct packed {
		pixel_t px;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic last;
	} filtered_t;

	class filter_scoreboard;
		pixel_t upper_line [MAX_WIDTH_DEF];
		pixel_t lower_line [MAX_WIDTH_DEF];
		pixel_t window_cols [6];
		int unsigned col_pos;
		int unsigned row_pos;
		logic [MODE_W-1:0] mode_reg;
		logic [IMGW_W-1:0] width_reg;
		logic [IMGH_W-1:0] height_reg;
		filtered_t filtered_due [$];
		int unsigned pixels_taken;
		int unsigned results_checked;
		int unsigned errors;

		function new();
			foreach (window_cols[i]) window_cols[i] = '0;
			col_pos = 0;
			row_pos = 0;
			mode_reg = MODE_EDGE;
			width_reg = 11'd1024;
			height_reg = 13'd1024;
			pixels_taken = 0;
			results_checked = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FILTER_MODE: mode_reg = val[MODE_W-1:0];
				REG_IMAGE_WIDTH: width_reg = val[IMGW_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = val[IMGH_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return filtered_due.size();
		endfunction

		function logic [PIX_W-1:0] kernel_channel(pixel_t win [9], int ch);
			int centre, cross_sum, corner, acc;
			centre = int'(win[4][8*ch +: 8]);
			cross_sum = int'(win[1][8*ch +: 8]) + int'(win[3][8*ch +: 8]) +
				int'(win[5][8*ch +: 8]) + int'(win[7][8*ch +: 8]);
			corner = int'(win[0][8*ch +: 8]) + int'(win[2][8*ch +: 8]) +
				int'(win[6][8*ch +: 8]) + int'(win[8][8*ch +: 8]);
			case (mode_reg)
				MODE_EDGE: acc = 8 * centre - cross_sum - corner;
				MODE_BLUR: acc = ((centre + cross_sum + corner) * BLUR_SCALE) >>> 16;
				MODE_SHARPEN: acc = 5 * centre - cross_sum;
				default: acc = 0;
			endcase
			if (acc <= 0)
				return 8'd0;
			if (acc >= 255)
				return 8'd255;
			return acc[PIX_W-1:0];
		endfunction

		function void note_pixel(pixel_t px);
			pixel_t top, mid;
			pixel_t win [9];
			filtered_t due;
			int unsigned w, h;
			int i;
			w = (width_reg < MIN_DIM) ? MIN_DIM :
				(width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
			h = (height_reg < MIN_DIM) ? MIN_DIM :
				(height_reg > HEIGHT_MAX) ? HEIGHT_MAX : int'(height_reg);
			pixels_taken++;
			top = upper_line[col_pos];
			mid = lower_line[col_pos];
			upper_line[col_pos] = mid;
			lower_line[col_pos] = px;
			if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
				for (i = 0; i < 6; i++) win[i] = window_cols[i];
				win[6] = top;
				win[7] = mid;
				win[8] = px;
				for (i = 0; i < 3; i++) due.px[8*i +: 8] = kernel_channel(win, i);
				due.column = COL_W'(col_pos - 1);
				due.row = ROW_W'(row_pos - 1);
				due.last = (col_pos == w - 1) && (row_pos == h - 1);
				filtered_due.push_back(due);
			end
			for (i = 0; i < 3; i++) window_cols[i] = window_cols[i+3];
			window_cols[3] = top;
			window_cols[4] = mid;
			window_cols[5] = px;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h)
					row_pos = 0;
			end else if (row_pos >= h) begin
				row_pos = 0;
			end
		endfunction

		function void check_result(filtered_t got);
			filtered_t want;
			if (filtered_due.size() == 0) begin
				errors++;
				$display("%0t: filtered pixel with none expected: rgb %0d/%0d/%0d at (%0d,%0d) last %0b",
					$time, got.px.red, got.px.green, got.px.blue, got.column, got.row, got.last);
			end else begin
				want = filtered_due.pop_front();
				results_checked++;
				if (got !== want) begin
					errors++;
					$display("%0t: filtered pixel mismatch: expected rgb %0d/%0d/%0d at (%0d,%0d) last %0b",
						$time, want.px.red, want.px.green, want.px.blue, want.column, want.row,
						want.last);
					$display("%0t:                          got      rgb %0d/%0d/%0d at (%0d,%0d) last %0b",
						$time, got.px.red, got.px.green, got.px.blue, got.column, got.row, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [PIX_W-1:0] pixel_red = '0;
	logic [PIX_W-1:0] pixel_green = '0;
	logic [PIX_W-1:0] pixel_blue = '0;
	logic empty;
	logic pop = 1'b0;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic [COL_W-1:0] out_column;
	logic [ROW_W-1:0] out_row;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	filter_scoreboard sb;
	bit tx_no_idle = 1'b0;
	bit rx_no_idle = 1'b0;
	bit hold_req = 1'b0;
	int unsigned full_cycles = 0;
	int unsigned reg_writes = 0;

	rgb_3x3_kernel_filter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue),
		.empty(empty),
		.pop(pop),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_column(out_column),
		.out_row(out_row),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Inputs change only at rising edges, so a handshake seen at the falling edge
	// is the one that the following rising edge takes.
	task automatic send_pixel(input pixel_t px);
		int unsigned pause;
		logic took;
		pause = tx_no_idle ? 0 : $urandom_range(0, 6);
		if (pause > 0) begin
			push <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		push <= 1'b1;
		pixel_red <= px.red;
		pixel_green <= px.green;
		pixel_blue <= px.blue;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
		sb.note_pixel(px);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		sb.set_reg(idx, val);
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : drain_results
		int unsigned pause;
		logic took;
		filtered_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				pause = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				pause = rx_no_idle ? 0 : $urandom_range(0, 6);
			end
			if (pause > 0) begin
				pop <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				took = !empty;
				got = {out_blue, out_green, out_red, out_column, out_row, frame_last};
				@(posedge clk);
			end while (!took);
			sb.check_result(got);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if (push && full)
				full_cycles++;
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int r, c, n, phase, random_pixels;
		int unsigned v;
		pixel_t px;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 3-wide frame of six rows gives one filtered pixel per row from the
		// third row on, each under a different mode, with extreme channel values.
		write_reg(REG_IMAGE_WIDTH, 13'd1);
		write_reg(REG_IMAGE_HEIGHT, 13'd6);
		for (r = 0; r < 6; r++) begin
			if (r >= 2) begin
				settle();
				write_reg(REG_FILTER_MODE, CFG_DATA_W'(DIRECTED_MODES[r-2]));
			end
			for (c = 0; c < 3; c++) begin
				px.red = (c == 1 && r % 2 == 1) ? 8'hFF : 8'h00;
				px.green = ~px.red;
				px.blue = 8'hFF;
				send_pixel(px);
			end
		end
		settle();

		// Wide rows write every line store entry that the later frames read.
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SHARPEN));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(WIDE_WIDTH));
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		tx_no_idle = 1'b1;
		repeat (WIDE_PIXELS) send_pixel(pixel_t'(24'($urandom)));
		tx_no_idle = 1'b0;
		settle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(3, 12)));

		phase = 0;
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			settle();
			phase++;
			tx_no_idle = ($urandom_range(0, 3) == 0);
			rx_no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
			if (phase == PRESSURE_PHASE) begin
				write_reg(REG_IMAGE_WIDTH, 13'd6);
				write_reg(REG_IMAGE_HEIGHT, 13'd8191);
				tx_no_idle = 1'b1;
				hold_req = 1'b1;
				n = 90;
			end else begin
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 9))
						0: v = $urandom_range(0, 2);
						1: v = $urandom_range(100, WIDE_WIDTH);
						2, 3, 4: v = $urandom_range(9, 40);
						default: v = $urandom_range(3, 8);
					endcase
					write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(v));
				end
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 9))
						0: v = $urandom_range(0, 2);
						1: v = $urandom_range(4000, 8191);
						2, 3: v = $urandom_range(9, 40);
						default: v = $urandom_range(3, 8);
					endcase
					write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(v));
				end
				n = $urandom_range(8, 90);
			end
			repeat (n) send_pixel(pixel_t'(24'($urandom)));
			random_pixels += n;
		end
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Fed %0d pixels across %0d register writes and checked %0d filtered pixels.",
			sb.pixels_taken, reg_writes, sb.results_checked);
		$display("All four modes, widths from 3 to %0d, heights up to 4096 and %0d full cycles were seen.",
			WIDE_WIDTH, full_cycles);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: rgb_3x3_kernel_filter_core.f
sv/rgbk_pkg.sv
sv/rgbk_ram.sv
sv/rgbk_front.sv
sv/rgbk_queue.sv
sv/rgbk_back.sv
sv/rgb_3x3_kernel_filter_core.sv
sv/rgbk_checker.sv
verif/rgb_3x3_kernel_filter_core_tb.sv
